// ===== rtl/gdpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdpc_pkg
// Shared types and constants for the grid digit pattern counter.
// ----------------------------------------------------------------------------
package gdpc_pkg;

    localparam int CELL_W    = 4;
    localparam int DIGITS_W  = 40;
    localparam int LEN_IN_W  = 4;
    localparam int COUNT_W   = 8;
    localparam int DIR_W     = 2;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam logic [CELL_W-1:0]  DIGIT_MAX = 4'd9;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd0;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
    localparam logic [DIR_W-1:0] DIR_UP    = 2'd3;

    typedef struct packed {
        logic load;
        logic start;
        logic run_begin;
        logic rd_en;
        logic step;
        logic next_run;
        logic count_inc;
        logic result_load;
    } gdpc_cmd_t;

    typedef struct packed {
        logic skip;
        logic run_fits;
        logic digit_match;
        logic last_digit;
        logic last_run;
        logic out_free;
    } gdpc_sts_t;

endpackage

// ===== rtl/gdpc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdpc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module gdpc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 36
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/gdpc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdpc_ctrl
// Search sequencer: walks start cells and directions, one digit per read.
// ----------------------------------------------------------------------------
module gdpc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_op,
    output logic               in_ready,
    input  gdpc_pkg::gdpc_sts_t sts,
    output gdpc_pkg::gdpc_cmd_t cmd
);

    import gdpc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_READ,
        ST_CMP,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   ready_next;
    logic   accept;

    assign accept = in_valid && ready_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_op == OP_LOAD))
                begin
                    cmd.load = 1'b1;
                end
                else if (accept)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (sts.skip)
                begin
                    state_next = ST_DONE;
                end
                else if (sts.run_fits)
                begin
                    cmd.run_begin = 1'b1;
                    state_next    = ST_READ;
                end
                else
                begin
                    cmd.next_run = 1'b1;
                    state_next   = sts.last_run ? ST_DONE : ST_RUN;
                end
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (sts.digit_match && !sts.last_digit)
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_READ;
                end
                else
                begin
                    cmd.count_inc = sts.digit_match;
                    cmd.next_run  = 1'b1;
                    state_next    = sts.last_run ? ST_DONE : ST_RUN;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign ready_next = (state_next == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign in_ready = ready_reg;

endmodule

// ===== rtl/gdpc_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdpc_dp
// Datapath: grid store, load position, run counters, digit compare, result.
// ----------------------------------------------------------------------------
module gdpc_dp #(
    parameter int GRID_SIDE  = 6,
    parameter int MAX_DIGITS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  gdpc_pkg::gdpc_cmd_t                 cmd,
    output gdpc_pkg::gdpc_sts_t                 sts,
    input  logic [gdpc_pkg::CELL_W-1:0]         cell_value,
    input  logic [gdpc_pkg::DIGITS_W-1:0]       pattern_digits,
    input  logic [gdpc_pkg::LEN_IN_W-1:0]       pattern_length,
    output logic [gdpc_pkg::COUNT_W-1:0]        match_count,
    output logic                                grid_invalid,
    output logic                                out_valid,
    input  logic                                out_ready
);

    import gdpc_pkg::*;

    localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int RC_W       = $clog2(GRID_SIDE);
    localparam int LEN_W      = $clog2(MAX_DIGITS + 1);
    localparam int K_W        = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int PAT_W      = MAX_DIGITS * CELL_W;
    localparam int FIT_W      = ((RC_W > LEN_W) ? RC_W : LEN_W) + 2;

    localparam logic [LEN_IN_W:0]  LEN_CAP    = (LEN_IN_W + 1)'(MAX_DIGITS);
    localparam logic [ADDR_W-1:0]  LAST_ADDR  = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0]  SIDE_ADDR  = ADDR_W'(GRID_SIDE);
    localparam logic [RC_W-1:0]    LAST_COL   = RC_W'(GRID_SIDE - 1);
    localparam logic [FIT_W-1:0]   SIDE_FIT   = FIT_W'(GRID_SIDE);

    logic [ADDR_W-1:0]  load_pos_reg,   load_pos_next;
    logic               invalid_reg,    invalid_next;
    logic               out_valid_reg,  out_valid_next;
    logic [COUNT_W-1:0] result_reg,     result_next;
    logic               res_inv_reg,    res_inv_next;
    logic [PAT_W-1:0]   pat_reg,        pat_next;
    logic [LEN_W-1:0]   len_reg,        len_next;
    logic [ADDR_W-1:0]  start_addr_reg, start_addr_next;
    logic [RC_W-1:0]    start_row_reg,  start_row_next;
    logic [RC_W-1:0]    start_col_reg,  start_col_next;
    logic [DIR_W-1:0]   dir_reg,        dir_next;
    logic [ADDR_W-1:0]  cur_addr_reg,   cur_addr_next;
    logic [K_W-1:0]     k_reg,          k_next;
    logic [COUNT_W-1:0] count_reg,      count_next;

    logic [PAT_W+DIGITS_W-1:0] pat_wide;
    logic [LEN_IN_W:0]         len_wide;
    logic [LEN_IN_W:0]         len_sat;
    logic [CELL_W-1:0]         rd_data;
    logic [CELL_W-1:0]         pat_digit;
    logic [FIT_W-1:0]          row_fit;
    logic [FIT_W-1:0]          col_fit;
    logic [FIT_W-1:0]          len_fit;
    logic                      fits;
    logic                      cell_bad;

    gdpc_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_grid (
        .clk     (clk),
        .wr_en   (cmd.load),
        .wr_addr (load_pos_reg),
        .wr_data (cell_value),
        .rd_en   (cmd.rd_en),
        .rd_addr (cur_addr_reg),
        .rd_data (rd_data)
    );

    assign pat_wide  = {{PAT_W{1'b0}}, pattern_digits};
    assign len_wide  = {1'b0, pattern_length};
    assign len_sat   = (len_wide > LEN_CAP) ? LEN_CAP : len_wide;
    assign cell_bad  = (cell_value > DIGIT_MAX);
    assign pat_digit = pat_reg[k_reg*CELL_W +: CELL_W];

    assign row_fit = FIT_W'(start_row_reg);
    assign col_fit = FIT_W'(start_col_reg);
    assign len_fit = FIT_W'(len_reg);

    always_comb
    begin
        case (dir_reg)
            DIR_RIGHT: fits = (col_fit + len_fit) <= SIDE_FIT;
            DIR_DOWN:  fits = (row_fit + len_fit) <= SIDE_FIT;
            DIR_LEFT:  fits = (col_fit + FIT_W'(1)) >= len_fit;
            DIR_UP:    fits = (row_fit + FIT_W'(1)) >= len_fit;
            default:   fits = 1'b0;
        endcase
    end

    assign sts.skip        = invalid_reg || (len_reg == '0);
    assign sts.run_fits    = fits;
    assign sts.digit_match = (rd_data == pat_digit);
    assign sts.last_digit  = ((LEN_W + 1)'(k_reg) + (LEN_W + 1)'(1)) == {1'b0, len_reg};
    assign sts.last_run    = (dir_reg == DIR_UP) && (start_addr_reg == LAST_ADDR);
    assign sts.out_free    = !out_valid_reg || out_ready;

    always_comb
    begin
        load_pos_next  = load_pos_reg;
        invalid_next   = invalid_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        res_inv_next   = res_inv_reg;
        pat_next       = pat_reg;
        len_next       = len_reg;
        start_addr_next = start_addr_reg;
        start_row_next = start_row_reg;
        start_col_next = start_col_reg;
        dir_next       = dir_reg;
        cur_addr_next  = cur_addr_reg;
        k_next         = k_reg;
        count_next     = count_reg;

        if (cmd.load)
        begin
            load_pos_next = (load_pos_reg == LAST_ADDR) ? '0 : load_pos_reg + ADDR_W'(1);
            invalid_next  = (load_pos_reg == '0) ? cell_bad : (invalid_reg || cell_bad);
        end

        if (cmd.start)
        begin
            pat_next        = pat_wide[PAT_W-1:0];
            len_next        = LEN_W'(len_sat);
            start_addr_next = '0;
            start_row_next  = '0;
            start_col_next  = '0;
            dir_next        = DIR_RIGHT;
            count_next      = '0;
        end

        if (cmd.run_begin)
        begin
            cur_addr_next = start_addr_reg;
            k_next        = '0;
        end

        if (cmd.step)
        begin
            k_next = k_reg + K_W'(1);
            case (dir_reg)
                DIR_RIGHT: cur_addr_next = cur_addr_reg + ADDR_W'(1);
                DIR_DOWN:  cur_addr_next = cur_addr_reg + SIDE_ADDR;
                DIR_LEFT:  cur_addr_next = cur_addr_reg - ADDR_W'(1);
                DIR_UP:    cur_addr_next = cur_addr_reg - SIDE_ADDR;
                default:   cur_addr_next = cur_addr_reg;
            endcase
        end

        if (cmd.count_inc && (count_reg != COUNT_MAX))
        begin
            count_next = count_reg + COUNT_W'(1);
        end

        if (cmd.next_run)
        begin
            if (dir_reg == DIR_UP)
            begin
                dir_next        = DIR_RIGHT;
                start_addr_next = start_addr_reg + ADDR_W'(1);
                if (start_col_reg == LAST_COL)
                begin
                    start_col_next = '0;
                    start_row_next = start_row_reg + RC_W'(1);
                end
                else
                begin
                    start_col_next = start_col_reg + RC_W'(1);
                end
            end
            else
            begin
                dir_next = dir_reg + DIR_W'(1);
            end
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.result_load)
        begin
            out_valid_next = 1'b1;
            result_next    = invalid_reg ? '0 : count_reg;
            res_inv_next   = invalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_pos_reg  <= '0;
            invalid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            load_pos_reg  <= load_pos_next;
            invalid_reg   <= invalid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg     <= result_next;
        res_inv_reg    <= res_inv_next;
        pat_reg        <= pat_next;
        len_reg        <= len_next;
        start_addr_reg <= start_addr_next;
        start_row_reg  <= start_row_next;
        start_col_reg  <= start_col_next;
        dir_reg        <= dir_next;
        cur_addr_reg   <= cur_addr_next;
        k_reg          <= k_next;
        count_reg      <= count_next;
    end

    assign match_count  = result_reg;
    assign grid_invalid = res_inv_reg;
    assign out_valid    = out_valid_reg;

endmodule

// ===== rtl/grid_digit_pattern_counter.sv =====
`timescale 1ns / 1ps
// Timing: a load writes one grid cell and leaves the block ready; a search walks one run
//   per start cell and direction (4*GRID_SIDE^2 runs), reading its digits one by one on the single
//   RAM read port and comparing each. An invalid grid or an empty pattern skips all runs.
// Throughput: one search in flight; the next transaction is taken once its result is
//   registered, later while the output is held.
// Reset: clears load position, invalid flag and output valid; grid contents are not cleared.
// ----------------------------------------------------------------------------
// grid_digit_pattern_counter
// Counts start cells and directions at which a decimal pattern reads straight in a grid.
// ----------------------------------------------------------------------------
module grid_digit_pattern_counter #(
    parameter int GRID_SIDE  = 6,
    parameter int MAX_DIGITS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // cell_value[3:0], pattern_digits[43:4],
                                        // pattern_length[47:44]
    input  logic        s_axis_tuser,   // op[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // match_count[7:0]
    output logic        m_axis_tuser    // grid_invalid[0]
);

    import gdpc_pkg::*;

    gdpc_cmd_t cmd;
    gdpc_sts_t sts;

    gdpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (s_axis_tuser),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gdpc_dp #(
        .GRID_SIDE  (GRID_SIDE),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cell_value     (s_axis_tdata[3:0]),
        .pattern_digits (s_axis_tdata[43:4]),
        .pattern_length (s_axis_tdata[47:44]),
        .match_count    (m_axis_tdata),
        .grid_invalid   (m_axis_tuser),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready)
    );

`ifndef SYNTHESIS
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("invalid grid result carries a nonzero count");

    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_SEARCH) |=> !s_axis_tready)
        else $error("ready stayed high after a search transaction");

    a_result_after_search: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without a search in progress");
`endif

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the grid digit pattern counter. Loads grids cell by
// cell, issues searches and compares every returned count and invalid flag
// against a shadow grid held in the bench, under several sender and receiver
// idle mixes and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

    import gdpc_pkg::*;

    localparam int GRID_SIDE    = 6;
    localparam int MAX_DIGITS   = 10;
    localparam int CELL_TOTAL   = GRID_SIDE * GRID_SIDE;
    localparam int DRAIN_CYCLES = 3 + 4 * CELL_TOTAL * (1 + 2 * MAX_DIGITS) + 16;
    localparam int RANDOM_ITEMS = 1300;

    typedef struct packed {
        logic [COUNT_W-1:0] match_count;
        logic               grid_invalid;
    } tally_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // cell_value[3:0], pattern_digits[43:4],
                                      // pattern_length[47:44]
    logic        s_axis_tuser = 1'b0; // op[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // match_count[7:0]
    logic        m_axis_tuser;        // grid_invalid[0]

    logic [CELL_W-1:0] grid_shadow [CELL_TOTAL];
    int                load_ptr = 0;
    logic              grid_bad = 1'b0;
    tally_t            expected_tallies [$];
    int                error_count = 0;
    int                items_sent = 0;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                hold_cycles = 0;

    grid_digit_pattern_counter #(
        .GRID_SIDE  (GRID_SIDE),
        .MAX_DIGITS (MAX_DIGITS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic void run_step(input logic [DIR_W-1:0] dir, output int dr, output int dc);
        dr = 0;
        dc = 0;
        case (dir)
            DIR_RIGHT: dc = 1;
            DIR_DOWN:  dr = 1;
            DIR_LEFT:  dc = -1;
            DIR_UP:    dr = -1;
            default:   dr = 0;
        endcase
    endfunction

    function automatic tally_t tally_pattern_runs(input logic [DIGITS_W-1:0] digits,
                                                  input logic [LEN_IN_W-1:0] len_in);
        tally_t res;
        int     len;
        int     dr;
        int     dc;
        int     r;
        int     c;
        logic   hit;
        res.match_count  = '0;
        res.grid_invalid = grid_bad;
        len = (len_in > MAX_DIGITS) ? MAX_DIGITS : int'(len_in);
        if (!grid_bad && len > 0)
        begin
            for (int row = 0; row < GRID_SIDE; row++)
            begin
                for (int col = 0; col < GRID_SIDE; col++)
                begin
                    for (int d = 0; d < 4; d++)
                    begin
                        run_step(d[DIR_W-1:0], dr, dc);
                        hit = 1'b1;
                        for (int k = 0; k < len; k++)
                        begin
                            r = row + dr * k;
                            c = col + dc * k;
                            if (r < 0 || r >= GRID_SIDE || c < 0 || c >= GRID_SIDE)
                                hit = 1'b0;
                            else if (grid_shadow[r * GRID_SIDE + c] != digits[4 * k +: 4])
                                hit = 1'b0;
                        end
                        if (hit && res.match_count != COUNT_MAX)
                            res.match_count++;
                    end
                end
            end
        end
        return res;
    endfunction

    task automatic send_item(input logic op, input logic [CELL_W-1:0] cell_val,
                             input logic [DIGITS_W-1:0] digits,
                             input logic [LEN_IN_W-1:0] len_in);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {len_in, digits, cell_val};
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        items_sent++;
        if (op == OP_LOAD)
        begin
            grid_shadow[load_ptr] = cell_val;
            if (load_ptr == 0)
                grid_bad = (cell_val > DIGIT_MAX);
            else if (cell_val > DIGIT_MAX)
                grid_bad = 1'b1;
            load_ptr = (load_ptr + 1) % CELL_TOTAL;
        end
        else
            expected_tallies.push_back(tally_pattern_runs(digits, len_in));
    endtask

    task automatic load_cell(input logic [CELL_W-1:0] v);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        send_item(OP_LOAD, v, junk[DIGITS_W-1:0], junk[47:44]);
    endtask

    task automatic search_pattern(input logic [DIGITS_W-1:0] digits,
                                  input logic [LEN_IN_W-1:0] len_in);
        logic [31:0] junk;
        junk = $urandom;
        send_item(OP_SEARCH, junk[CELL_W-1:0], digits, len_in);
    endtask

    task automatic wait_results_drained();
        while (expected_tallies.size() != 0)
            @(posedge clk);
    endtask

    task automatic load_random_grid();
        logic [CELL_W-1:0] d0;
        logic [CELL_W-1:0] d1;
        logic              wide;
        int                bad_at;
        d0     = CELL_W'($urandom_range(9));
        d1     = CELL_W'($urandom_range(9));
        wide   = ($urandom_range(3) == 0);
        bad_at = ($urandom_range(9) == 0) ? int'($urandom_range(CELL_TOTAL - 1)) : -1;
        for (int i = 0; i < CELL_TOTAL; i++)
        begin
            if (i == bad_at)
                load_cell(CELL_W'($urandom_range(15, 10)));
            else if (wide)
                load_cell(CELL_W'($urandom_range(9)));
            else
                load_cell($urandom_range(1) ? d1 : d0);
        end
    endtask

    task automatic search_from_grid();
        int                  row;
        int                  col;
        int                  len;
        int                  pick;
        int                  dr;
        int                  dc;
        int                  r;
        int                  c;
        int                  k;
        logic [DIR_W-1:0]    dir;
        logic [63:0]         bits;
        logic [DIGITS_W-1:0] digits;
        row  = $urandom_range(GRID_SIDE - 1);
        col  = $urandom_range(GRID_SIDE - 1);
        dir  = DIR_W'($urandom_range(3));
        pick = $urandom_range(99);
        if (pick < 75)
            len = $urandom_range(3, 1);
        else if (pick < 95)
            len = $urandom_range(6, 4);
        else
            len = $urandom_range(MAX_DIGITS, 7);
        bits   = {$urandom, $urandom};
        digits = bits[DIGITS_W-1:0];
        run_step(dir, dr, dc);
        for (int i = 0; i < len; i++)
        begin
            r = row + dr * i;
            c = col + dc * i;
            if (r < 0 || r >= GRID_SIDE || c < 0 || c >= GRID_SIDE)
                digits[4 * i +: 4] = CELL_W'($urandom_range(9));
            else
                digits[4 * i +: 4] = grid_shadow[r * GRID_SIDE + c];
        end
        if ($urandom_range(7) == 0)
        begin
            k = $urandom_range(len - 1);
            digits[4 * k +: 4] = CELL_W'($urandom);
        end
        search_pattern(digits, LEN_IN_W'(len));
    endtask

    task automatic test_uniform_grid();
        for (int i = 0; i < CELL_TOTAL; i++)
            load_cell('0);
        search_pattern('0, 4'd1);
        search_pattern(40'hFF_FFFF_FFF0, 4'd1);
        search_pattern('0, 4'd6);
        search_pattern('0, 4'd7);
        search_pattern('0, 4'd10);
        search_pattern('0, 4'd15);
        search_pattern('0, 4'd0);
        search_pattern(40'h1, 4'd1);
    endtask

    task automatic test_digit_grid();
        for (int i = 0; i < CELL_TOTAL; i++)
            load_cell(CELL_W'(((i / GRID_SIDE) + (i % GRID_SIDE)) % 10));
        search_pattern(40'h9, 4'd1);
        search_pattern(40'hA, 4'd1);
        search_pattern(40'hF, 4'd1);
        search_pattern(40'h98, 4'd2);
        search_pattern(40'h54_3210, 4'd6);
        search_pattern(40'h01_2345, 4'd6);
        search_pattern(40'h98_7654_3210, 4'd10);
    endtask

    task automatic test_invalid_grid();
        load_cell(4'hF);
        search_pattern(40'h9, 4'd1);
        for (int i = 1; i < CELL_TOTAL; i++)
            load_cell(DIGIT_MAX);
        search_pattern(40'h9, 4'd1);
        load_cell(DIGIT_MAX);
        search_pattern(40'h9, 4'd1);
        load_cell(4'hC);
        search_pattern(40'h9, 4'd1);
    endtask

    task automatic test_random_traffic();
        int target;
        int pick;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            target = items_sent + RANDOM_ITEMS / 4;
            while (items_sent < target)
            begin
                pick = $urandom_range(99);
                if (pick < 65)
                    load_random_grid();
                else if (pick < 85)
                begin
                    repeat ($urandom_range(12, 1))
                    begin
                        if ($urandom_range(7) == 0)
                            load_cell(CELL_W'($urandom_range(15, 10)));
                        else
                            load_cell(CELL_W'($urandom_range(9)));
                    end
                end
                repeat ($urandom_range(6, 2))
                begin
                    if ($urandom_range(4) == 0)
                        search_pattern(DIGITS_W'({$urandom, $urandom}),
                                       LEN_IN_W'($urandom_range(15)));
                    else
                        search_from_grid();
                end
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_output_backpressure();
        for (int i = 0; i < CELL_TOTAL; i++)
            load_cell('0);
        hold_cycles = 3000;
        repeat (6)
            search_pattern('0, 4'd3);
    endtask

    // receiver: hold off while hold_cycles runs down, else stall at random
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_cycles--;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        tally_t want;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_tallies.size() == 0)
                begin
                    $display("%0t: unexpected transaction: match_count %0d grid_invalid %0b",
                             $time, m_axis_tdata, m_axis_tuser);
                    error_count++;
                end
                else
                begin
                    want = expected_tallies.pop_front();
                    if (m_axis_tdata !== want.match_count)
                    begin
                        $display("%0t: match_count expected %0d actual %0d",
                                 $time, want.match_count, m_axis_tdata);
                        error_count++;
                    end
                    if (m_axis_tuser !== want.grid_invalid)
                    begin
                        $display("%0t: grid_invalid expected %0b actual %0b",
                                 $time, want.grid_invalid, m_axis_tuser);
                        error_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        #1_000_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_uniform_grid();
        test_digit_grid();
        test_invalid_grid();
        test_random_traffic();
        test_output_backpressure();
        s_axis_tvalid <= 1'b0;
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== grid_digit_pattern_counter.f =====
rtl/gdpc_pkg.sv
rtl/gdpc_ram.sv
rtl/gdpc_ctrl.sv
rtl/gdpc_dp.sv
rtl/grid_digit_pattern_counter.sv
dv/testbench.sv
